// File: src/qte_pkg.sv
// Shared types, constants and the arctangent table for the quaternion to Euler angle block.
package qte_pkg;

    // Width of the CORDIC datapath and of the angle accumulator.
    localparam int CW = 36;
    localparam int AW = 32;

    // Fixed-point constants in Q.30.
    localparam logic signed [CW-1:0] Q_ONE  = 36'sh0_4000_0000;
    localparam logic signed [CW-1:0] Q_MONE = -36'sh0_4000_0000;
    localparam logic signed [CW-1:0] Q_HALF = 36'sh0_2000_0000;

    // Index of each component product.
    localparam int NPROD = 9;
    localparam int P_WX = 0;
    localparam int P_YZ = 1;
    localparam int P_XZ = 2;
    localparam int P_WY = 3;
    localparam int P_XX = 4;
    localparam int P_YY = 5;
    localparam int P_XY = 6;
    localparam int P_WZ = 7;
    localparam int P_ZZ = 8;

    // Index of each atan2 lane that runs beside the pitch lane.
    localparam int NLANE   = 3;
    localparam int LN_YAW  = 0;
    localparam int LN_ROLL = 1;
    localparam int LN_YAWL = 2;

    // Binary angle of a quarter turn in 16 bits.
    localparam logic signed [17:0] QUARTER = 18'sd16384;
    localparam logic [AW-1:0]       ANG_PI  = 32'h8000_0000;
    localparam logic [AW-1:0]       ANG_RND = 32'h0000_8000;

    // atan(2^-i) as a 32-bit binary angle.
    localparam logic [AW-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Operands and start angle of one atan2 lane.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [AW-1:0]        ang;
    } t_vec;

    // What travels beside the square root.
    typedef struct packed {
        logic signed [31:0]     s;
        logic                   clamp;
        t_vec [NLANE-1:0]       lane;
    } t_mid;

endpackage

// File: src/qte_if.sv
// Valid/ready channel interfaces for quaternion beats in and angle beats out.
interface qte_in_if #(parameter int COMPONENT_BITS = 16);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] quat_w;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
    logic               gimbal_lock;
    logic               asin_clamped;

    modport source (output valid, pitch_angle, yaw_angle, roll_angle, gimbal_lock,
                    asin_clamped, input ready);
    modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, gimbal_lock,
                    asin_clamped, output ready);
endinterface

// File: src/quaternion_to_euler_angles_core.sv
// Throughput is one beat per cycle; the whole pipeline advances together and halts only
// while the output register holds a beat that the sink has not taken.
// The square root that gives the pitch cosine takes 31 stages, one result bit per stage, and
// sets most of the latency. Reset is synchronous and active low: it empties every
// stage and loads the gimbal lock distance with 8. No clearing pass is needed.
module quaternion_to_euler_angles_core #(
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_gimbal_eps_we,
    input  logic [14:0] i_gimbal_eps,
    qte_in_if.sink      i_quat,
    qte_out_if.source   o_euler
);

    localparam int PW    = 2 * COMPONENT_BITS;
    localparam int RW    = 62;
    localparam int ISQ   = 31;
    localparam int DLY   = ISQ + 1;
    localparam int NSTG  = 4 + ISQ + CORDIC_STEPS + 1;

    // Gimbal lock distance; the user must write it only while the block is idle, the block does not enforce this.
    logic [14:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 15'd8;
        end else if (i_gimbal_eps_we) begin
            r_eps <= i_gimbal_eps;
        end
    end

    // One valid bit per stage. Every stage moves when the output register is free or
    // is being emptied in this cycle, so a stall neither drops nor repeats a beat.
    logic [NSTG-1:0] r_vld;
    logic            en;

    assign en           = !r_vld[NSTG-1] || o_euler.ready;
    assign i_quat.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_quat.valid};
        end
    end

    // Stage 0: the nine component products, each brought to Q.30.
    logic signed [COMPONENT_BITS-1:0] opa [qte_pkg::NPROD];
    logic signed [COMPONENT_BITS-1:0] opb [qte_pkg::NPROD];
    logic signed [31:0]               r_prod [qte_pkg::NPROD];

    always_comb begin
        opa[qte_pkg::P_WX] = i_quat.quat_w;  opb[qte_pkg::P_WX] = i_quat.quat_x;
        opa[qte_pkg::P_YZ] = i_quat.quat_y;  opb[qte_pkg::P_YZ] = i_quat.quat_z;
        opa[qte_pkg::P_XZ] = i_quat.quat_x;  opb[qte_pkg::P_XZ] = i_quat.quat_z;
        opa[qte_pkg::P_WY] = i_quat.quat_w;  opb[qte_pkg::P_WY] = i_quat.quat_y;
        opa[qte_pkg::P_XX] = i_quat.quat_x;  opb[qte_pkg::P_XX] = i_quat.quat_x;
        opa[qte_pkg::P_YY] = i_quat.quat_y;  opb[qte_pkg::P_YY] = i_quat.quat_y;
        opa[qte_pkg::P_XY] = i_quat.quat_x;  opb[qte_pkg::P_XY] = i_quat.quat_y;
        opa[qte_pkg::P_WZ] = i_quat.quat_w;  opb[qte_pkg::P_WZ] = i_quat.quat_z;
        opa[qte_pkg::P_ZZ] = i_quat.quat_z;  opb[qte_pkg::P_ZZ] = i_quat.quat_z;
    end

    for (genvar k = 0; k < qte_pkg::NPROD; k++) begin : g_prod
        logic signed [PW-1:0] full;
        logic signed [31:0]   q30;

        assign full = opa[k] * opb[k];

        // Wide components drop low bits (floor); narrow ones gain zero low bits.
        if (PW >= 32) begin : g_shr
            assign q30 = full[PW-1 -: 32];
        end else begin : g_shl
            assign q30 = {full, {(32-PW){1'b0}}};
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_prod[k] <= q30;
            end
        end
    end

    // Stage 1: sums. The asin argument is saturated to the unit range here.
    logic signed [qte_pkg::CW-1:0] ex [qte_pkg::NPROD];
    logic signed [qte_pkg::CW-1:0] s_raw, s_sat;
    logic                          s_clamp;
    logic signed [31:0]            r_s1;
    logic                          r_clamp1;
    logic signed [qte_pkg::CW-1:0] r_yn, r_xn, r_yr, r_xr, r_yl, r_xl;

    for (genvar k = 0; k < qte_pkg::NPROD; k++) begin : g_ext
        assign ex[k] = {{(qte_pkg::CW-32){r_prod[k][31]}}, r_prod[k]};
    end

    always_comb begin
        s_raw = (ex[qte_pkg::P_WX] - ex[qte_pkg::P_YZ]) <<< 1;
        unique if (s_raw > qte_pkg::Q_ONE) begin
            s_sat   = qte_pkg::Q_ONE;
            s_clamp = 1'b1;
        end else if (s_raw < qte_pkg::Q_MONE) begin
            s_sat   = qte_pkg::Q_MONE;
            s_clamp = 1'b1;
        end else begin
            s_sat   = s_raw;
            s_clamp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1     <= s_sat[31:0];
            r_clamp1 <= s_clamp;
            r_yn     <= ex[qte_pkg::P_XZ] + ex[qte_pkg::P_WY];
            r_xn     <= qte_pkg::Q_HALF - ex[qte_pkg::P_XX] - ex[qte_pkg::P_YY];
            r_yr     <= ex[qte_pkg::P_XY] + ex[qte_pkg::P_WZ];
            r_xr     <= qte_pkg::Q_HALF - ex[qte_pkg::P_XX] - ex[qte_pkg::P_ZZ];
            r_yl     <= ex[qte_pkg::P_WY] - ex[qte_pkg::P_XZ];
            r_xl     <= qte_pkg::Q_HALF - ex[qte_pkg::P_YY] - ex[qte_pkg::P_ZZ];
        end
    end

    // Stage 2: square of the sine, and the half-plane fold of the three atan2 lanes.
    // A negative real part negates both parts of the lane and the lane starts from half a turn.
    logic [30:0]             s_abs;
    logic [RW-1:0]           sq_c;
    logic [RW-1:0]           r_sq;
    logic signed [qte_pkg::CW-1:0] lx [qte_pkg::NLANE];
    logic signed [qte_pkg::CW-1:0] ly [qte_pkg::NLANE];
    qte_pkg::t_mid           n_mid;
    qte_pkg::t_mid           r_mid;

    assign s_abs = r_s1[31] ? 31'(-r_s1) : r_s1[30:0];
    assign sq_c  = {31'd0, s_abs} * {31'd0, s_abs};

    always_comb begin
        lx[qte_pkg::LN_YAW]  = r_xn;  ly[qte_pkg::LN_YAW]  = r_yn;
        lx[qte_pkg::LN_ROLL] = r_xr;  ly[qte_pkg::LN_ROLL] = r_yr;
        lx[qte_pkg::LN_YAWL] = r_xl;  ly[qte_pkg::LN_YAWL] = r_yl;
        n_mid.s     = r_s1;
        n_mid.clamp = r_clamp1;
        for (int j = 0; j < qte_pkg::NLANE; j++) begin
            if (lx[j] < 0) begin
                n_mid.lane[j].x   = -lx[j];
                n_mid.lane[j].y   = -ly[j];
                n_mid.lane[j].ang = qte_pkg::ANG_PI;
            end else begin
                n_mid.lane[j].x   = lx[j];
                n_mid.lane[j].y   = ly[j];
                n_mid.lane[j].ang = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq  <= sq_c;
            r_mid <= n_mid;
        end
    end

    // Stage 3: radicand 1 - s^2 in Q.60.
    logic [RW-1:0] r_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= (RW'(1) << 60) - r_sq;
        end
    end

    // Stages 3 to 34: the lane operands wait beside the radicand and the square root.
    qte_pkg::t_mid r_dly [DLY];

    for (genvar k = 0; k < DLY; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dly[k] <= (k == 0) ? r_mid : r_dly[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Stages 4 to 34: integer square root, one result bit per stage.
    logic [RW-1:0] r_rn [ISQ];
    logic [RW-1:0] r_rr [ISQ];

    for (genvar k = 0; k < ISQ; k++) begin : g_isqrt
        logic [RW-1:0] pn, pr, trial;
        localparam logic [RW-1:0] BITV = RW'(1) << (60 - 2*k);

        if (k == 0) begin : g_first
            assign pn = r_rad;
            assign pr = '0;
        end else begin : g_next
            assign pn = r_rn[k-1];
            assign pr = r_rr[k-1];
        end

        assign trial = pr + BITV;

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (pn >= trial) begin
                    r_rn[k] <= pn - trial;
                    r_rr[k] <= (pr >> 1) + BITV;
                end else begin
                    r_rn[k] <= pn;
                    r_rr[k] <= pr >> 1;
                end
            end
        end
    end

    // Four CORDIC lanes side by side: pitch, yaw, roll and the gimbal lock yaw.
    // The cosine is never negative, so the pitch lane needs no fold.
    logic signed [qte_pkg::CW-1:0] pitch_x, pitch_y;
    logic [qte_pkg::AW-1:0]        ang_out [qte_pkg::NLANE+1];

    assign pitch_x = r_rr[ISQ-1][qte_pkg::CW-1:0];
    assign pitch_y = {{(qte_pkg::CW-32){r_dly[DLY-1].s[31]}}, r_dly[DLY-1].s};

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (pitch_x),
        .i_y   (pitch_y),
        .i_ang ('0),
        .o_ang (ang_out[qte_pkg::NLANE])
    );

    for (genvar j = 0; j < qte_pkg::NLANE; j++) begin : g_lane
        qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (r_dly[DLY-1].lane[j].x),
            .i_y   (r_dly[DLY-1].lane[j].y),
            .i_ang (r_dly[DLY-1].lane[j].ang),
            .o_ang (ang_out[j])
        );
    end

    // The saturation flag follows the CORDIC lanes.
    logic r_cd [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cdly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cd[k] <= (k == 0) ? r_dly[DLY-1].clamp : r_cd[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Last stage: round each angle half up to 16 bits, decide gimbal lock from the
    // distance of |pitch| to a quarter turn, and pick the yaw and roll that apply.
    logic [qte_pkg::AW-1:0] rnd [qte_pkg::NLANE+1];
    logic signed [16:0]     p_ext, p_abs;
    logic signed [17:0]     lock_gap, lock_gap_abs;
    logic                   lock;
    logic signed [15:0]     r_pitch, r_yaw, r_roll;
    logic                   r_lock, r_clamp;

    always_comb begin
        for (int j = 0; j <= qte_pkg::NLANE; j++) begin
            rnd[j] = ang_out[j] + qte_pkg::ANG_RND;
        end
        p_ext        = {rnd[qte_pkg::NLANE][31], rnd[qte_pkg::NLANE][31:16]};
        p_abs        = (p_ext < 0) ? -p_ext : p_ext;
        lock_gap     = {p_abs[16], p_abs} - qte_pkg::QUARTER;
        lock_gap_abs = (lock_gap < 0) ? -lock_gap : lock_gap;
        lock         = lock_gap_abs <= $signed({3'b000, r_eps});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pitch <= rnd[qte_pkg::NLANE][31:16];
            r_yaw   <= lock ? rnd[qte_pkg::LN_YAWL][31:16] : rnd[qte_pkg::LN_YAW][31:16];
            r_roll  <= lock ? 16'sd0 : rnd[qte_pkg::LN_ROLL][31:16];
            r_lock  <= lock;
            r_clamp <= r_cd[CORDIC_STEPS-1];
        end
    end

    assign o_euler.valid        = r_vld[NSTG-1];
    assign o_euler.pitch_angle  = r_pitch;
    assign o_euler.yaw_angle    = r_yaw;
    assign o_euler.roll_angle   = r_roll;
    assign o_euler.gimbal_lock  = r_lock;
    assign o_euler.asin_clamped = r_clamp;

endmodule

// File: src/qte_cordic.sv
// Pipelined vectoring CORDIC lane, one micro-rotation per register stage.
module qte_cordic #(
    parameter int STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [qte_pkg::CW-1:0] i_x,
    input  logic signed [qte_pkg::CW-1:0] i_y,
    input  logic [qte_pkg::AW-1:0]        i_ang,
    output logic [qte_pkg::AW-1:0]        o_ang
);

    logic signed [qte_pkg::CW-1:0] r_x   [STEPS];
    logic signed [qte_pkg::CW-1:0] r_y   [STEPS];
    logic [qte_pkg::AW-1:0]        r_ang [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [qte_pkg::CW-1:0] px, py, n_x, n_y;
        logic [qte_pkg::AW-1:0]        pa, n_ang;

        if (i == 0) begin : g_first
            assign px = i_x;
            assign py = i_y;
            assign pa = i_ang;
        end else begin : g_next
            assign px = r_x[i-1];
            assign py = r_y[i-1];
            assign pa = r_ang[i-1];
        end

        // Once y reaches zero the vector stays put for the rest of the lane.
        always_comb begin
            unique if (py > 0) begin
                n_x   = px + (py >>> i);
                n_y   = py - (px >>> i);
                n_ang = pa + qte_pkg::ATAN_TAB[i];
            end else if (py < 0) begin
                n_x   = px - (py >>> i);
                n_y   = py + (px >>> i);
                n_ang = pa - qte_pkg::ATAN_TAB[i];
            end else begin
                n_x   = px;
                n_y   = py;
                n_ang = pa;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i]   <= n_x;
                r_y[i]   <= n_y;
                r_ang[i] <= n_ang;
            end
        end
    end

    assign o_ang = r_ang[STEPS-1];

endmodule

// File: src/qte_checker.sv
// Port-level checks for the quaternion to Euler angle block, bound to its top level.
module qte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_roll,
    input logic [15:0] i_yaw,
    input logic [15:0] i_pitch,
    input logic        i_lock
);

    // The input side moves exactly when the output register can move.
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow the output stall");

    // Gimbal lock always comes with a zero roll.
    a_lock_roll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_lock) |-> (i_roll == 16'd0))
        else $error("roll is not zero in gimbal lock");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat shown straight after reset");

    // A stalled result beat stays offered with the same payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pitch) && $stable(i_yaw) && $stable(i_roll)))
        else $error("stalled result beat changed");

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_quat.ready),
    .i_out_valid (o_euler.valid),
    .i_out_ready (o_euler.ready),
    .i_roll      (o_euler.roll_angle),
    .i_yaw       (o_euler.yaw_angle),
    .i_pitch     (o_euler.pitch_angle),
    .i_lock      (o_euler.gimbal_lock)
);
